/* hdl/pfc_pkg.sv */
// Shared constants, tables and helpers for the Playfair digraph cipher.
`default_nettype none

package pfc_pkg;

  localparam int unsigned SIDE   = 5;
  localparam int unsigned CELLS  = SIDE * SIDE;
  localparam int unsigned CHAR_W = 8;
  localparam int unsigned POS_W  = $clog2(CELLS);
  localparam int unsigned IDX_W  = $clog2(SIDE);

  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned CFG_ADDR_W = 5;

  localparam logic MODE_ENCRYPT = 1'b0;
  localparam logic MODE_DECRYPT = 1'b1;

  typedef logic [CHAR_W-1:0] char_t;
  typedef logic [POS_W-1:0]  pos_t;
  typedef logic [IDX_W-1:0]  idx_t;

  localparam idx_t ROW_OF [CELLS] = '{
    3'd0, 3'd0, 3'd0, 3'd0, 3'd0,
    3'd1, 3'd1, 3'd1, 3'd1, 3'd1,
    3'd2, 3'd2, 3'd2, 3'd2, 3'd2,
    3'd3, 3'd3, 3'd3, 3'd3, 3'd3,
    3'd4, 3'd4, 3'd4, 3'd4, 3'd4
  };

  localparam idx_t COL_OF [CELLS] = '{
    3'd0, 3'd1, 3'd2, 3'd3, 3'd4,
    3'd0, 3'd1, 3'd2, 3'd3, 3'd4,
    3'd0, 3'd1, 3'd2, 3'd3, 3'd4,
    3'd0, 3'd1, 3'd2, 3'd3, 3'd4,
    3'd0, 3'd1, 3'd2, 3'd3, 3'd4
  };

  localparam idx_t LAST_IDX = idx_t'(SIDE - 1);

  function automatic idx_t wrap_step(input idx_t v, input logic mode);
    idx_t r;
    if (mode == MODE_DECRYPT) begin
      r = (v == '0) ? LAST_IDX : idx_t'(v - 1'b1);
    end else begin
      r = (v == LAST_IDX) ? '0 : idx_t'(v + 1'b1);
    end
    return r;
  endfunction

  function automatic pos_t cell_of(input idx_t row, input idx_t col);
    pos_t r;
    r = pos_t'({row, 2'b00}) + pos_t'(row) + pos_t'(col);
    return r;
  endfunction

endpackage

`default_nettype wire

/* hdl/playfair_digraph_cipher.sv */
// Top level of the Playfair digraph cipher with its register port and stream channels.
`default_nettype none

// The block takes one letter pair per cycle while the result side is not stalled and
// returns the enciphered or deciphered pair through an input register, the square
// lookup and cell selection in between, and a result register. The 5x5 key square
// is loaded through the register port and must only be changed while no request is in
// flight. A letter missing from the square, and the second of two identical letters,
// count as the top left cell.
module playfair_digraph_cipher (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [pfc_pkg::CFG_ADDR_W-1:0]     paddr,
  input  wire logic [pfc_pkg::CFG_DATA_W-1:0]     pwdata,
  output      logic [pfc_pkg::CFG_DATA_W-1:0]     prdata,
  output      logic                               pready,
  input  wire logic                               s_tvalid,
  output      logic                               s_tready,
  // first_letter [7:0], second_letter [15:8]
  input  wire logic [15:0]                        s_tdata,
  // mode [0]
  input  wire logic                               s_tuser,
  output      logic                               m_tvalid,
  input  wire logic                               m_tready,
  // first_out [7:0], second_out [15:8]
  output      logic [15:0]                        m_tdata
);
  import pfc_pkg::*;

  localparam logic [1:0] REG_KEY_A    = 2'd0;
  localparam logic [1:0] REG_KEY_B    = 2'd1;
  localparam logic [1:0] REG_KEY_C    = 2'd2;
  localparam logic [1:0] REG_KEY_LAST = 2'd3;

  logic [63:0] key_a;
  logic [63:0] key_b;
  logic [63:0] key_c;
  char_t       key_last;
  logic [CELLS*CHAR_W-1:0] key_flat;

  logic        cfg_write;
  logic [1:0]  reg_index;

  logic        s1_valid;
  logic        s1_mode;
  char_t       s1_first;
  char_t       s1_second;
  logic        out_load;

  pos_t  pos1;
  pos_t  pos2;
  idx_t  r1, c1, r2, c2;
  pos_t  o1, o2;
  char_t first_next;
  char_t second_next;

  assign pready    = 1'b1;
  assign reg_index = paddr[4:3];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_a    <= '0;
      key_b    <= '0;
      key_c    <= '0;
      key_last <= '0;
    end else if (cfg_write) begin
      case (reg_index)
        REG_KEY_A:    key_a    <= pwdata;
        REG_KEY_B:    key_b    <= pwdata;
        REG_KEY_C:    key_c    <= pwdata;
        REG_KEY_LAST: key_last <= pwdata[CHAR_W-1:0];
        default:      key_a    <= key_a;
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      REG_KEY_A:    prdata = key_a;
      REG_KEY_B:    prdata = key_b;
      REG_KEY_C:    prdata = key_c;
      REG_KEY_LAST: prdata = CFG_DATA_W'(key_last);
      default:      prdata = '0;
    endcase
  end

  assign key_flat = {key_last, key_c, key_b, key_a};

  assign out_load = s1_valid && (!m_tvalid || m_tready);
  assign s_tready = !s1_valid || out_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (s_tready) begin
        s1_valid <= s_tvalid;
      end
      if (!m_tvalid || m_tready) begin
        m_tvalid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      s1_mode   <= s_tuser;
      s1_first  <= s_tdata[7:0];
      s1_second <= s_tdata[15:8];
    end
    if (out_load) begin
      m_tdata <= {second_next, first_next};
    end
  end

  // The last matching cell wins; no match leaves the top left cell.
  always_comb begin
    pos1 = '0;
    pos2 = '0;
    for (int k = 0; k < CELLS; k++) begin
      if (key_flat[CHAR_W*k +: CHAR_W] == s1_first) begin
        pos1 = pos_t'(k);
      end
      if (key_flat[CHAR_W*k +: CHAR_W] == s1_second) begin
        pos2 = pos_t'(k);
      end
    end
    if (s1_first == s1_second) begin
      pos2 = '0;
    end
  end

  always_comb begin
    r1 = ROW_OF[pos1];
    c1 = COL_OF[pos1];
    r2 = ROW_OF[pos2];
    c2 = COL_OF[pos2];
    if (r1 == r2) begin
      o1 = cell_of(r1, wrap_step(c1, s1_mode));
      o2 = cell_of(r2, wrap_step(c2, s1_mode));
    end else if (c1 == c2) begin
      o1 = cell_of(wrap_step(r1, s1_mode), c1);
      o2 = cell_of(wrap_step(r2, s1_mode), c2);
    end else begin
      o1 = cell_of(r1, c2);
      o2 = cell_of(r2, c1);
    end
    first_next  = key_flat[CHAR_W*o1 +: CHAR_W];
    second_next = key_flat[CHAR_W*o2 +: CHAR_W];
  end

endmodule

`default_nettype wire

/* hdl/pfc_checker.sv */
// Port-level checks for the Playfair digraph cipher and their bind to the top level.
`default_nettype none

module pfc_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [15:0] m_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed or dropped while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid right after reset");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
    else $error("result appeared without a request two cycles earlier");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !m_tready)
    else $error("input stalled while the output side was free");

endmodule

bind playfair_digraph_cipher pfc_checker u_pfc_checker (.*);

`default_nettype wire
